[sv/rws_pkg.sv]
package rws_pkg;

    localparam int MAX_ENTRIES_DEF  = 64;
    localparam int FITNESS_BITS_DEF = 32;
    localparam int RANDOM_BITS_DEF  = 16;

    localparam int FIT_PORT_W = 32;
    localparam int RND_PORT_W = 16;
    localparam int IDX_PORT_W = 6;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ADD_LOAD,
        ADD_MUL,
        ADD_SCAN
    } add_sel_t;

    typedef struct packed {
        logic     load_en;
        logic     load_clear;
        logic     sel_start;
        logic     mul_step;
        logic     mul_last;
        logic     scan_step;
        logic     out_load;
        add_sel_t add_sel;
    } ctrl_t;

    typedef struct packed {
        logic count_zero;
        logic scan_stop;
    } status_t;

endpackage

[sv/rws_in_if.sv]
interface rws_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic                            starts_new_set;
    logic [rws_pkg::FIT_PORT_W-1:0]  fitness_value;
    logic [rws_pkg::RND_PORT_W-1:0]  random_fraction;

    modport source (
        output valid, op, starts_new_set, fitness_value, random_fraction,
        input  ready
    );

    modport sink (
        input  valid, op, starts_new_set, fitness_value, random_fraction,
        output ready
    );
endinterface

[sv/rws_out_if.sv]
interface rws_out_if;
    logic                            valid;
    logic                            ready;
    logic [rws_pkg::IDX_PORT_W-1:0]  chosen_index;
    logic                            set_empty;
    logic                            load_overflow;

    modport source (
        output valid, chosen_index, set_empty, load_overflow,
        input  ready
    );

    modport sink (
        input  valid, chosen_index, set_empty, load_overflow,
        output ready
    );
endinterface

[sv/rws_store.sv]
module rws_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/rws_ctrl.sv]
module rws_ctrl #(
    parameter int RANDOM_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_op,
    input  logic             item_start,
    input  logic             out_free,
    input  rws_pkg::status_t stat,
    output logic             item_ready,
    output rws_pkg::ctrl_t   ctl
);
    import rws_pkg::*;

    localparam int R_W   = (RANDOM_BITS < RND_PORT_W) ? RANDOM_BITS : RND_PORT_W;
    localparam int BIT_W = $clog2(R_W);

    state_t            state_reg, state_next;
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic              accept;
    logic              bit_last;

    assign accept   = item_valid && (state_reg == ST_IDLE);
    assign bit_last = (bit_cnt_reg == BIT_W'(R_W - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item_op == OP_SELECT))
                begin
                    state_next = stat.count_zero ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (bit_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready     = 1'b0;
        ctl            = '0;
        ctl.add_sel    = ADD_LOAD;
        ctl.load_clear = item_start;
        bit_cnt_next   = bit_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready    = 1'b1;
                ctl.load_en   = accept && (item_op == OP_LOAD);
                ctl.sel_start = accept && (item_op == OP_SELECT);
                bit_cnt_next  = '0;
            end
            ST_MUL:
            begin
                ctl.add_sel  = ADD_MUL;
                ctl.mul_step = 1'b1;
                ctl.mul_last = bit_last;
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
            ST_SCAN:
            begin
                ctl.add_sel   = ADD_SCAN;
                ctl.scan_step = 1'b1;
            end
            ST_DONE:
            begin
                ctl.out_load = out_free;
            end
            default:
            begin
                ctl.add_sel = ADD_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

endmodule

[sv/rws_datapath.sv]
module rws_datapath #(
    parameter int MAX_ENTRIES  = 64,
    parameter int FITNESS_BITS = 32,
    parameter int RANDOM_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rws_pkg::ctrl_t                  ctl,
    input  logic [rws_pkg::FIT_PORT_W-1:0]  fitness_in,
    input  logic [rws_pkg::RND_PORT_W-1:0]  random_in,
    output rws_pkg::status_t                stat,
    output logic [$clog2(MAX_ENTRIES)-1:0]  idx,
    output logic                            empty,
    output logic                            overflow
);
    import rws_pkg::*;

    localparam int F_W   = (FITNESS_BITS < FIT_PORT_W) ? FITNESS_BITS : FIT_PORT_W;
    localparam int R_W   = (RANDOM_BITS < RND_PORT_W) ? RANDOM_BITS : RND_PORT_W;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = F_W + IDX_W;
    localparam int ACC_W = SUM_W + R_W;

    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             ovf_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [SUM_W-1:0] thr_reg;
    logic [R_W-1:0]   rnd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             empty_reg;

    logic [CNT_W-1:0] base_cnt;
    logic [SUM_W-1:0] base_sum;
    logic             full;
    logic             store_we;
    logic [IDX_W-1:0] raddr;
    logic [F_W-1:0]   rdata;
    logic [ACC_W-1:0] add_a, add_b, add_out;
    logic             hit, last;

    assign base_cnt = ctl.load_clear ? '0 : count_reg;
    assign base_sum = ctl.load_clear ? '0 : sum_reg;
    assign full     = (base_cnt == CNT_W'(MAX_ENTRIES));
    assign store_we = ctl.load_en && !full;

    assign raddr = !ctl.scan_step ? '0 :
                   (idx_reg == IDX_W'(MAX_ENTRIES - 1)) ? '0 : idx_reg + 1'b1;

    rws_store #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (F_W)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (base_cnt[IDX_W-1:0]),
        .wdata (fitness_in[F_W-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    // shared adder: load sum, shift-add multiply, prefix accumulate
    always_comb
    begin
        case (ctl.add_sel)
            ADD_LOAD:
            begin
                add_a = ACC_W'(base_sum);
                add_b = ACC_W'(fitness_in[F_W-1:0]);
            end
            ADD_MUL:
            begin
                add_a = acc_reg << 1;
                add_b = rnd_reg[R_W-1] ? ACC_W'(sum_reg) : '0;
            end
            ADD_SCAN:
            begin
                add_a = acc_reg;
                add_b = ACC_W'(rdata);
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_out = add_a + add_b;

    assign hit  = (add_out[SUM_W-1:0] > thr_reg);
    assign last = (idx_reg == IDX_W'(count_reg - 1'b1));

    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_stop  = hit || last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (ctl.load_en)
        begin
            if (full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                count_reg <= base_cnt + 1'b1;
                sum_reg   <= add_out[SUM_W-1:0];
                if (ctl.load_clear)
                begin
                    ovf_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sel_start)
        begin
            acc_reg   <= '0;
            rnd_reg   <= random_in[R_W-1:0];
            idx_reg   <= '0;
            empty_reg <= (count_reg == '0);
        end
        else if (ctl.mul_step)
        begin
            rnd_reg <= rnd_reg << 1;
            if (ctl.mul_last)
            begin
                thr_reg <= SUM_W'(add_out >> RANDOM_BITS);
                acc_reg <= '0;
            end
            else
            begin
                acc_reg <= add_out;
            end
        end
        else if (ctl.scan_step)
        begin
            acc_reg <= add_out;
            if (!stat.scan_stop)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign idx      = idx_reg;
    assign empty    = empty_reg;
    assign overflow = ovf_reg;

endmodule

[sv/roulette_wheel_select_core.sv]
// Load transaction: accepted while idle; ready stays high, so loads can run back to back.
// Select transaction: one shift-add step per random bit, then a scan of one stored value per
// cycle until the running sum exceeds the threshold or the last entry is reached; the result
// is loaded once the result register is free. Select on an empty set skips both steps. The
// input is not ready during a select and is ready again when the result is loaded.
// rst_n (async, active low) empties the set and clears the overflow flag; no clearing pass.
module roulette_wheel_select_core #(
    parameter int MAX_ENTRIES  = rws_pkg::MAX_ENTRIES_DEF,
    parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF,
    parameter int RANDOM_BITS  = rws_pkg::RANDOM_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rws_in_if.sink    item,
    rws_out_if.source result
);
    import rws_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    ctrl_t               ctl;
    status_t             stat;
    logic                out_free;
    logic [IDX_W-1:0]    dp_idx;
    logic                dp_empty;
    logic                dp_ovf;
    logic [IDX_W+IDX_PORT_W-1:0] idx_wide;

    logic                  res_valid_reg;
    logic [IDX_PORT_W-1:0] res_idx_reg;
    logic                  res_empty_reg;
    logic                  res_ovf_reg;

    assign out_free = !res_valid_reg || result.ready;
    assign idx_wide = {{IDX_PORT_W{1'b0}}, dp_idx};

    rws_ctrl #(
        .RANDOM_BITS (RANDOM_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_op    (item.op),
        .item_start (item.starts_new_set),
        .out_free   (out_free),
        .stat       (stat),
        .item_ready (item.ready),
        .ctl        (ctl)
    );

    rws_datapath #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .FITNESS_BITS (FITNESS_BITS),
        .RANDOM_BITS  (RANDOM_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .fitness_in (item.fitness_value),
        .random_in  (item.random_fraction),
        .stat       (stat),
        .idx        (dp_idx),
        .empty      (dp_empty),
        .overflow   (dp_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            res_idx_reg   <= idx_wide[IDX_PORT_W-1:0];
            res_empty_reg <= dp_empty;
            res_ovf_reg   <= dp_ovf;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.chosen_index  = res_idx_reg;
    assign result.set_empty     = res_empty_reg;
    assign result.load_overflow = res_ovf_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!res_valid_reg || result.ready))
        else $error("result register overwritten while occupied");

    a_no_load_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !item.ready)
        else $error("result loaded while accepting input");

    a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.op == OP_SELECT)) |=> !item.ready)
        else $error("ready after select transaction");

    a_empty_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_empty_reg) |-> (res_idx_reg == '0))
        else $error("empty set with non-zero index");

endmodule
